/* src/ffba_pkg.sv */
`default_nettype none
package ffba_pkg;
    localparam int FREE_SLOTS = 16;
    localparam int LIVE_SLOTS = 32;
    localparam int ADDR_BITS  = 20;
    localparam int FIDX_BITS  = $clog2(FREE_SLOTS);
    localparam int FCNT_BITS  = $clog2(FREE_SLOTS + 1);
    localparam int LIDX_BITS  = $clog2(LIVE_SLOTS);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOFIT   = 2'd1;
    localparam t_status ST_UNKNOWN = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam t_addr HEAP_RESET = '1;

    // command broadcast to every extent cell
    typedef enum logic [2:0] {
        C_NONE,
        C_INIT,
        C_CARVE,
        C_DROP,
        C_GROW_SIZE,
        C_SET_NEXT,
        C_INSERT
    } t_cmd;

    typedef struct packed {
        t_cmd  cmd;
        logic [FIDX_BITS-1:0] idx;
        t_addr start;
        t_addr size;
    } t_cell_ctl;

    typedef struct packed {
        t_addr start;
        t_addr size;
    } t_ext;
endpackage
`default_nettype wire

/* src/ffba_if.sv */
`default_nettype none
interface ffba_req_if;
    import ffba_pkg::*;
    logic  valid;
    logic  ready;
    logic  op;
    t_addr size_blocks;
    t_addr addr_block;
    modport source (output valid, op, size_blocks, addr_block, input ready);
    modport sink (input valid, op, size_blocks, addr_block, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_addr   result_block;
    modport source (output valid, status, result_block, input ready);
    modport sink (input valid, status, result_block, output ready);
endinterface
`default_nettype wire

/* src/first_fit_block_allocator_core.sv */
`default_nettype none
// an allocate scans the extent cells and then the live table ram, a free scans the
// live table ram and then the extent cells; one request at a time, a new one is
// taken only in idle, once the last result has moved on to the output register
// reset: one free extent of 1048575 blocks, empty live table; writing heap_blocks
// does the same with the new size
module first_fit_block_allocator_core
    import ffba_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire t_addr i_cfg_wdata,
    ffba_req_if.sink   i_req,
    ffba_rsp_if.source o_rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_ASCAN, S_LSCAN, S_LWAIT, S_FREAD, S_FPOS, S_FMERGE,
        S_FDROP, S_OUT
    } t_state;

    t_state r_state;
    t_addr  r_heap;
    logic   r_init;
    t_cell_ctl ctl;
    t_ext   ext [FREE_SLOTS];
    t_ext   zero_ext;
    logic [FCNT_BITS-1:0] r_cnt;
    logic [FCNT_BITS-1:0] r_i;
    logic [LIDX_BITS:0]   r_j;
    logic [LIVE_SLOTS-1:0] r_lvalid;
    t_addr  r_n, r_a, r_need, r_s, r_z;
    logic [FIDX_BITS-1:0] r_hit;
    logic [LIDX_BITS-1:0] r_slot;
    t_status r_st;
    t_addr  r_res;
    t_status r_out_st;
    t_addr  r_out_res;
    logic   r_ovalid;
    logic   r_pending;

    logic   ram_we;
    logic [LIDX_BITS-1:0] ram_waddr, ram_raddr;
    logic [2*ADDR_BITS-1:0] ram_wdata, ram_rdata;

    assign zero_ext = '0;

    genvar g;
    generate
        for (g = 0; g < FREE_SLOTS; g++) begin : g_cell
            ffba_cell u_cell (
                .i_clk  (i_clk),
                .i_pos  (FIDX_BITS'(g)),
                .i_ctl  (ctl),
                .i_left ((g == 0) ? zero_ext : ext[(g == 0) ? 0 : g-1]),
                .i_right((g == FREE_SLOTS-1) ? zero_ext : ext[(g == FREE_SLOTS-1) ? g : g+1]),
                .o_ext  (ext[g])
            );
        end
    endgenerate

    ffba_ram #(.WIDTH(2*ADDR_BITS), .DEPTH(LIVE_SLOTS)) u_live (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic [FIDX_BITS-1:0] ci;
    logic [FIDX_BITS-1:0] pm1;
    t_ext ecur, eprev;
    logic in_range, with_prev, with_next;
    t_addr  ls, lz;

    assign ci = r_i[FIDX_BITS-1:0];
    assign pm1 = ci - 1'b1;
    assign ecur = ext[ci];
    assign eprev = ext[pm1];
    assign in_range = (r_i < r_cnt);
    assign ls = ram_rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign lz = ram_rdata[ADDR_BITS-1:0];
    assign with_prev = (r_i != '0) && (eprev.start + eprev.size == r_s);
    assign with_next = in_range && (r_s + r_z == ecur.start);

    assign ram_raddr = r_j[LIDX_BITS-1:0];
    assign ram_waddr = r_j[LIDX_BITS-1:0];
    assign ram_wdata = {ext[r_hit].start, r_need};
    assign ram_we = (r_state == S_LSCAN) && !r_j[LIDX_BITS] && !r_lvalid[r_j[LIDX_BITS-1:0]];

    always_comb begin
        ctl = '{cmd: C_NONE, idx: '0, start: '0, size: '0};
        if (r_init) begin
            ctl.cmd  = C_INIT;
            ctl.size = r_heap;
        end else begin
            case (r_state)
                S_LSCAN: begin
                    if (ram_we) begin
                        ctl.cmd  = C_CARVE;
                        ctl.idx  = r_hit;
                        ctl.size = r_need;
                    end
                end
                S_FMERGE: begin
                    if (with_prev) begin
                        ctl.cmd  = C_GROW_SIZE;
                        ctl.idx  = pm1;
                        ctl.size = eprev.size + r_z + (with_next ? ecur.size : '0);
                    end else if (with_next) begin
                        ctl.cmd   = C_SET_NEXT;
                        ctl.idx   = ci;
                        ctl.start = r_s;
                        ctl.size  = ecur.size + r_z;
                    end else if (r_cnt < FCNT_BITS'(FREE_SLOTS)) begin
                        ctl.cmd   = C_INSERT;
                        ctl.idx   = ci;
                        ctl.start = r_s;
                        ctl.size  = r_z;
                    end
                end
                S_FDROP: begin
                    ctl.cmd = C_DROP;
                    ctl.idx = r_hit;
                end
                default: ctl.cmd = C_NONE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_pending && !r_init;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_out_st;
    assign o_rsp.result_block = r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_heap    <= HEAP_RESET;
            r_init    <= 1'b1;
            r_cnt     <= '0;
            r_lvalid  <= '0;
            r_ovalid  <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_heap <= i_cfg_wdata;
                r_init <= 1'b1;
            end else if (r_init) begin
                r_init   <= 1'b0;
                r_cnt    <= (r_heap != '0) ? FCNT_BITS'(1) : '0;
                r_lvalid <= '0;
            end
            if (r_pending && !r_ovalid) begin
                r_pending <= 1'b0;
                r_ovalid  <= 1'b1;
                r_out_st  <= r_st;
                r_out_res <= r_res;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_n    <= i_req.size_blocks;
                        r_a    <= i_req.addr_block;
                        r_need <= i_req.size_blocks + 1'b1;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_res  <= '0;
                        if (i_req.op == OP_ALLOC) begin
                            if (i_req.size_blocks == '0) begin
                                r_st    <= ST_NOFIT;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_ASCAN;
                            end
                        end else begin
                            r_state <= S_FREAD;
                        end
                    end
                end
                S_ASCAN: begin
                    if (!in_range) begin
                        r_st    <= ST_NOFIT;
                        r_state <= S_OUT;
                    end else if ({1'b0, ecur.size} >= {1'b0, r_n} + 1'b1) begin
                        r_hit   <= ci;
                        r_state <= S_LSCAN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_LSCAN: begin
                    if (r_j[LIDX_BITS]) begin
                        r_st    <= ST_FULL;
                        r_state <= S_OUT;
                    end else if (ram_we) begin
                        r_lvalid[r_j[LIDX_BITS-1:0]] <= 1'b1;
                        r_res <= ext[r_hit].start + 1'b1;
                        r_st  <= ST_OK;
                        if (ext[r_hit].size == r_need) r_state <= S_FDROP;
                        else r_state <= S_OUT;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    r_slot <= r_j[LIDX_BITS-1:0];
                end
                S_FREAD: begin
                    r_state <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (r_lvalid[r_j[LIDX_BITS-1:0]] && (ls + 1'b1 == r_a)) begin
                        r_slot  <= r_j[LIDX_BITS-1:0];
                        r_s     <= ls;
                        r_z     <= lz;
                        r_state <= S_FPOS;
                    end else if (r_j == (LIDX_BITS+1)'(LIVE_SLOTS-1)) begin
                        r_st    <= ST_UNKNOWN;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_FREAD;
                    end
                end
                S_FPOS: begin
                    if (in_range && (ecur.start <= r_s)) r_i <= r_i + 1'b1;
                    else r_state <= S_FMERGE;
                end
                S_FMERGE: begin
                    r_st <= ST_OK;
                    r_state <= S_OUT;
                    if (with_prev && with_next) begin
                        r_hit <= ci;
                        r_state <= S_FDROP;
                        r_lvalid[r_slot] <= 1'b0;
                    end else if (with_prev || with_next) begin
                        r_lvalid[r_slot] <= 1'b0;
                    end else if (r_cnt < FCNT_BITS'(FREE_SLOTS)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_lvalid[r_slot] <= 1'b0;
                    end else begin
                        r_st <= ST_FULL;
                    end
                end
                S_FDROP: begin
                    r_cnt   <= r_cnt - 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_pending <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/ffba_cell.sv */
`default_nettype none
module ffba_cell
    import ffba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [FIDX_BITS-1:0] i_pos,
    input  wire t_cell_ctl            i_ctl,
    input  wire t_ext                 i_left,
    input  wire t_ext                 i_right,
    output t_ext                      o_ext
);
    t_ext r_ext;
    t_ext n_ext;

    always_comb begin
        n_ext = r_ext;
        case (i_ctl.cmd)
            C_INIT: begin
                n_ext.start = '0;
                n_ext.size  = i_ctl.size;
            end
            C_CARVE: begin
                if (i_pos == i_ctl.idx) begin
                    n_ext.start = r_ext.start + i_ctl.size;
                    n_ext.size  = r_ext.size - i_ctl.size;
                end
            end
            C_DROP: begin
                if (i_pos >= i_ctl.idx) n_ext = i_right;
            end
            C_GROW_SIZE: begin
                if (i_pos == i_ctl.idx) n_ext.size = i_ctl.size;
            end
            C_SET_NEXT: begin
                if (i_pos == i_ctl.idx) begin
                    n_ext.start = i_ctl.start;
                    n_ext.size  = i_ctl.size;
                end
            end
            C_INSERT: begin
                if (i_pos == i_ctl.idx) begin
                    n_ext.start = i_ctl.start;
                    n_ext.size  = i_ctl.size;
                end else if (i_pos > i_ctl.idx) begin
                    n_ext = i_left;
                end
            end
            default: n_ext = r_ext;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ext <= n_ext;
    end

    assign o_ext = r_ext;
endmodule
`default_nettype wire

/* src/ffba_ram.sv */
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire
